>>> hw/rtl/quadrature_wheel_position_motor_drive_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the quadrature wheel position / motor drive unit
// Shared concurrent assertion forms, clocked on clk, off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef QUADRATURE_WHEEL_POSITION_MOTOR_DRIVE_UNIT_DEFINES_SVH
`define QUADRATURE_WHEEL_POSITION_MOTOR_DRIVE_UNIT_DEFINES_SVH

// same-cycle implication
`define QWP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QWP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/qwp_pkg.sv
// ---------------------------------------------------------------------------
// qwp_pkg
// Shared constants, types and tables of the wheel position / drive unit.
// ---------------------------------------------------------------------------
`default_nettype none

package qwp_pkg;

  // default limits
  localparam int QWP_ENCODER_LIMIT   = 5040;
  localparam int QWP_WHEEL_LIMIT_DEG = 360;

  // full-scale force magnitude
  localparam int QWP_FORCE_FULL = 10000;

  // field widths
  localparam int QWP_FORCE_W = 16;
  localparam int QWP_POS_W   = 14;
  localparam int QWP_DEG_W   = 10;
  localparam int QWP_DUTY_W  = 8;
  localparam int QWP_MAG_W   = $clog2(QWP_FORCE_FULL + 1);

  // configuration registers
  localparam int QWP_CFG_IDX_W = 1;
  localparam logic [QWP_CFG_IDX_W-1:0] QWP_CFG_DUTY_MIN = 1'd0;
  localparam logic [QWP_CFG_IDX_W-1:0] QWP_CFG_DUTY_MAX = 1'd1;

  localparam logic [QWP_DUTY_W-1:0] QWP_DUTY_MIN_RST = 8'd80;
  localparam logic [QWP_DUTY_W-1:0] QWP_DUTY_MAX_RST = 8'd244;

  // 4x decode step, indexed by {last_phase, phase}, phase = {b, a}
  localparam logic signed [1:0] QWP_STEP_TBL [16] = '{
     2'sd0,  2'sd1, -2'sd1,  2'sd0,
    -2'sd1,  2'sd0,  2'sd0,  2'sd1,
     2'sd1,  2'sd0,  2'sd0, -2'sd1,
     2'sd0, -2'sd1,  2'sd1,  2'sd0
  };

  // per-request control flags carried down the pipe
  typedef struct packed {
    logic oor;       // raw count beyond the encoder limit
    logic frc_nz;    // force command nonzero
    logic to_right;  // duty goes to the right channel
  } qwp_flags_t;

endpackage

`default_nettype wire

>>> hw/rtl/qwp_decode.sv
// ---------------------------------------------------------------------------
// qwp_decode
// 4x quadrature decode, count clamp, force magnitude and channel choice.
// ---------------------------------------------------------------------------
`default_nettype none
`include "quadrature_wheel_position_motor_drive_unit_defines.svh"

module qwp_decode #(
  parameter int ENCODER_LIMIT = qwp_pkg::QWP_ENCODER_LIMIT,
  localparam int POS_W = $clog2(ENCODER_LIMIT + 1) + 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en_i,
  input  logic                               vld_i,
  input  logic                               phase_a_i,
  input  logic                               phase_b_i,
  input  logic signed [qwp_pkg::QWP_FORCE_W-1:0] force_i,
  output logic                               vld_o,
  output qwp_pkg::qwp_flags_t                flg_o,
  output logic signed [POS_W-1:0]            pos_o,
  output logic [qwp_pkg::QWP_MAG_W-1:0]      mag_o
);
  import qwp_pkg::*;

  localparam logic signed [31:0]      LIM_S   = 32'(ENCODER_LIMIT);
  localparam logic signed [POS_W-1:0] POS_MAX = POS_W'(ENCODER_LIMIT);
  localparam logic signed [POS_W-1:0] POS_MIN = -POS_MAX;

  logic [31:0]              raw_count_r;
  logic [31:0]              raw_count_nxt;
  logic [1:0]               last_phase_r;
  logic [1:0]               phase;
  logic signed [1:0]        step;
  logic signed [31:0]       count;
  logic signed [POS_W-1:0]  pos_nxt;
  logic                     oor_nxt;
  logic signed [QWP_FORCE_W:0] fext;
  logic signed [QWP_FORCE_W:0] fabs;
  logic [QWP_MAG_W-1:0]     mag_nxt;
  logic                     frc_neg;
  logic                     frc_nz;
  qwp_flags_t               flg_nxt;

  logic                     vld_r;
  qwp_flags_t               flg_r;
  logic signed [POS_W-1:0]  pos_r;
  logic [QWP_MAG_W-1:0]     mag_r;

  assign phase         = {phase_b_i, phase_a_i};
  assign step          = QWP_STEP_TBL[{last_phase_r, phase}];
  assign raw_count_nxt = raw_count_r + 32'(step);
  assign count         = $signed(raw_count_nxt);

  always_comb begin
    if (count > LIM_S) begin
      pos_nxt = POS_MAX;
      oor_nxt = 1'b1;
    end else if (count < -LIM_S) begin
      pos_nxt = POS_MIN;
      oor_nxt = 1'b1;
    end else begin
      pos_nxt = POS_W'(count);
      oor_nxt = 1'b0;
    end
  end

  // magnitude, saturated at full scale (covers the most negative code)
  assign frc_neg = force_i[QWP_FORCE_W-1];
  assign frc_nz  = (force_i != '0);
  assign fext    = (QWP_FORCE_W + 1)'(force_i);
  assign fabs    = frc_neg ? -fext : fext;
  assign mag_nxt = (fabs > (QWP_FORCE_W + 1)'(QWP_FORCE_FULL)) ?
                   QWP_MAG_W'(QWP_FORCE_FULL) : fabs[QWP_MAG_W-1:0];

  always_comb begin
    flg_nxt.oor    = oor_nxt;
    flg_nxt.frc_nz = frc_nz;
    // out of range: follow the position sign instead of the force
    flg_nxt.to_right = oor_nxt ? !pos_nxt[POS_W-1] : (frc_nz && !frc_neg);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= 1'b0;
      raw_count_r  <= '0;
      last_phase_r <= '0;
    end else if (en_i) begin
      vld_r <= vld_i;
      if (vld_i) begin
        raw_count_r  <= raw_count_nxt;
        last_phase_r <= phase;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      flg_r <= flg_nxt;
      pos_r <= pos_nxt;
      mag_r <= mag_nxt;
    end
  end

  assign vld_o = vld_r;
  assign flg_o = flg_r;
  assign pos_o = pos_r;
  assign mag_o = mag_r;

  `QWP_ASSERT_IMPL(a_oor_at_limit, vld_r && flg_r.oor, (pos_r == POS_MAX) || (pos_r == POS_MIN), "out of range without clamped position")
  `QWP_ASSERT_NXT(a_count_unit_step, en_i && vld_i, (raw_count_r == $past(raw_count_r)) || (raw_count_r == $past(raw_count_r) + 32'd1) || (raw_count_r == $past(raw_count_r) - 32'd1), "raw count moved by more than one")

endmodule

`default_nettype wire

>>> hw/rtl/qwp_cdiv.sv
// ---------------------------------------------------------------------------
// qwp_cdiv
// Divide by a constant through reciprocal multiplication, one register stage.
// ---------------------------------------------------------------------------
`default_nettype none

module qwp_cdiv #(
  parameter int NUM_W = 23,
  parameter int DEN   = qwp_pkg::QWP_ENCODER_LIMIT,
  parameter int QUO_W = 10
) (
  input  logic             clk,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  output logic [QUO_W-1:0] quo_o
);

  // floor(n / DEN) == (n * MUL) >> SHF for every NUM_W-bit n;
  // the quotient itself must fit in QUO_W bits
  localparam int              SHF    = NUM_W + $clog2(DEN);
  localparam int              PROD_W = SHF + QUO_W;
  localparam longint unsigned MUL    = ((64'd1 << SHF) + 64'(DEN) - 64'd1) / 64'(DEN);

  logic [PROD_W-1:0] prod;
  logic [QUO_W-1:0]  quo_r;

  assign prod = PROD_W'(num_i) * PROD_W'(MUL);

  always_ff @(posedge clk) begin
    if (en_i) begin
      quo_r <= prod[SHF +: QUO_W];
    end
  end

  assign quo_o = quo_r;

endmodule

`default_nettype wire

>>> hw/rtl/qwp_drive.sv
// ---------------------------------------------------------------------------
// qwp_drive
// Final stage: degrees offset, duty from quotient, held channel levels.
// ---------------------------------------------------------------------------
`default_nettype none
`include "quadrature_wheel_position_motor_drive_unit_defines.svh"

module qwp_drive #(
  parameter int ENCODER_LIMIT   = qwp_pkg::QWP_ENCODER_LIMIT,
  parameter int WHEEL_LIMIT_DEG = qwp_pkg::QWP_WHEEL_LIMIT_DEG,
  parameter int DEG_Q_W         = 10,
  localparam int POS_W = $clog2(ENCODER_LIMIT + 1) + 1
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en_i,
  input  logic                                 vld_i,
  input  qwp_pkg::qwp_flags_t                  flg_i,
  input  logic signed [POS_W-1:0]              pos_i,
  input  logic [DEG_Q_W-1:0]                   deg_q_i,
  input  logic [qwp_pkg::QWP_DUTY_W-1:0]       duty_q_i,
  input  logic [qwp_pkg::QWP_DUTY_W-1:0]       duty_min_i,
  input  logic [qwp_pkg::QWP_DUTY_W-1:0]       duty_max_i,
  output logic                                 vld_o,
  output logic signed [qwp_pkg::QWP_POS_W-1:0] position_o,
  output logic signed [qwp_pkg::QWP_DEG_W-1:0] wheel_degrees_o,
  output logic                                 out_of_range_o,
  output logic                                 motor_enable_o,
  output logic [qwp_pkg::QWP_DUTY_W-1:0]       right_duty_o,
  output logic [qwp_pkg::QWP_DUTY_W-1:0]       left_duty_o
);
  import qwp_pkg::*;

  logic signed [DEG_Q_W+1:0]     deg_s;
  logic [QWP_DUTY_W-1:0]         duty;

  logic                          vld_r;
  logic signed [QWP_POS_W-1:0]   pos_r;
  logic signed [QWP_DEG_W-1:0]   deg_r;
  logic                          oor_r;
  logic                          ena_r;
  logic [QWP_DUTY_W-1:0]         right_level_r;
  logic [QWP_DUTY_W-1:0]         left_level_r;

  assign deg_s = $signed({2'b00, deg_q_i}) - (DEG_Q_W + 2)'(WHEEL_LIMIT_DEG);

  // inverted range steps down from duty_min, truncating toward zero
  assign duty = (duty_max_i < duty_min_i) ? (duty_min_i - duty_q_i) :
                                            (duty_min_i + duty_q_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r         <= 1'b0;
      right_level_r <= '0;
      left_level_r  <= '0;
    end else if (en_i) begin
      vld_r <= vld_i;
      if (vld_i) begin
        if (flg_i.to_right) begin
          right_level_r <= duty;
        end else begin
          left_level_r <= duty;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      pos_r <= QWP_POS_W'(pos_i);
      deg_r <= QWP_DEG_W'(deg_s);
      oor_r <= flg_i.oor;
      ena_r <= flg_i.frc_nz;
    end
  end

  assign vld_o           = vld_r;
  assign position_o      = pos_r;
  assign wheel_degrees_o = deg_r;
  assign out_of_range_o  = oor_r;
  assign motor_enable_o  = ena_r;
  assign right_duty_o    = right_level_r;
  assign left_duty_o     = left_level_r;

  `QWP_ASSERT_NXT(a_right_hold, en_i && vld_i && !flg_i.to_right, right_level_r == $past(right_level_r), "right duty changed on a left request")

endmodule

`default_nettype wire

>>> hw/rtl/quadrature_wheel_position_motor_drive_unit.sv
// ---------------------------------------------------------------------------
// quadrature_wheel_position_motor_drive_unit
// Wheel encoder decode with clamp, degree scaling and H-bridge duty drive.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one request per encoder sample, the
//   two phase levels plus a signed force command. One request per cycle is
//   taken when in_stall is low; each request yields exactly one out_ result.
//   Result channel (out_valid / out_stall): clamped position, degrees, range
//   flag, motor enable and the held right / left PWM duties.
//   Pipeline: the input register, then decode/clamp, the two products, the
//   two constant divides (reciprocal multiply, one register each, side by
//   side) and the output register.
//   Throughput: one request per cycle, sustained while the pipe is not stalled.
//   Stall: the whole pipe freezes while out_valid is high and out_stall is
//   set; in_stall follows in the same cycle. Results are never dropped.
//   Config (cfg_valid / cfg_ready, always ready): index 0 duty_min, index 1
//   duty_max. Write only while the pipe is empty.
//   Reset (rst_n low, synchronous): count, last phase and both duty levels
//   go to zero, duty_min/duty_max to 80/244, the pipe empties.
// ---------------------------------------------------------------------------
`default_nettype none
`include "quadrature_wheel_position_motor_drive_unit_defines.svh"

module quadrature_wheel_position_motor_drive_unit #(
  parameter int ENCODER_LIMIT   = qwp_pkg::QWP_ENCODER_LIMIT,
  parameter int WHEEL_LIMIT_DEG = qwp_pkg::QWP_WHEEL_LIMIT_DEG
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // sample requests
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_phase_a,
  input  logic                                   in_phase_b,
  input  logic signed [qwp_pkg::QWP_FORCE_W-1:0] in_force_cmd,
  // results
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [qwp_pkg::QWP_POS_W-1:0]   out_position,
  output logic signed [qwp_pkg::QWP_DEG_W-1:0]   out_wheel_degrees,
  output logic                                   out_out_of_range,
  output logic                                   out_motor_enable,
  output logic [qwp_pkg::QWP_DUTY_W-1:0]         out_right_duty,
  output logic [qwp_pkg::QWP_DUTY_W-1:0]         out_left_duty,
  // configuration writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [qwp_pkg::QWP_CFG_IDX_W-1:0]      cfg_index,
  input  logic [qwp_pkg::QWP_DUTY_W-1:0]         cfg_data
);
  import qwp_pkg::*;

  localparam int POS_W       = $clog2(ENCODER_LIMIT + 1) + 1;
  localparam int DEG_NUM_W   = POS_W + $clog2(WHEEL_LIMIT_DEG + 1);
  localparam int DUTY_NUM_W  = QWP_MAG_W + QWP_DUTY_W;
  localparam int DEG_Q_W     = $clog2(2 * WHEEL_LIMIT_DEG + 1);
  localparam logic signed [POS_W-1:0] POS_MAX = POS_W'(ENCODER_LIMIT);

  // global advance: everything moves unless a finished result is held
  logic en;

  // config registers
  logic [QWP_DUTY_W-1:0] duty_min_r;
  logic [QWP_DUTY_W-1:0] duty_max_r;

  // S0: input register
  logic                          in_vld_r;
  logic                          in_pa_r;
  logic                          in_pb_r;
  logic signed [QWP_FORCE_W-1:0] in_force_r;

  // S1: decode outputs
  logic                    s1_vld;
  qwp_flags_t              s1_flg;
  logic signed [POS_W-1:0] s1_pos;
  logic [QWP_MAG_W-1:0]    s1_mag;

  // S2: products into the dividers
  logic [POS_W-1:0]        x_sum;
  logic [QWP_DUTY_W-1:0]   duty_span;
  logic                    s2_vld_r;
  qwp_flags_t              s2_flg_r;
  logic signed [POS_W-1:0] s2_pos_r;
  logic [DEG_NUM_W-1:0]    deg_num_r;
  logic [DUTY_NUM_W-1:0]   duty_num_r;

  // side band alongside the divider stage
  logic                    sb_vld_r;
  qwp_flags_t              sb_flg_r;
  logic signed [POS_W-1:0] sb_pos_r;

  logic [DEG_Q_W-1:0]      deg_q;
  logic [QWP_DUTY_W-1:0]   duty_q;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_min_r <= QWP_DUTY_MIN_RST;
      duty_max_r <= QWP_DUTY_MAX_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        QWP_CFG_DUTY_MIN: duty_min_r <= cfg_data;
        QWP_CFG_DUTY_MAX: duty_max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // S0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (en) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_pa_r    <= in_phase_a;
      in_pb_r    <= in_phase_b;
      in_force_r <= in_force_cmd;
    end
  end

  // S1: decode, clamp, magnitude; owns the count state
  qwp_decode #(
    .ENCODER_LIMIT(ENCODER_LIMIT)
  ) u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .en_i      (en),
    .vld_i     (in_vld_r),
    .phase_a_i (in_pa_r),
    .phase_b_i (in_pb_r),
    .force_i   (in_force_r),
    .vld_o     (s1_vld),
    .flg_o     (s1_flg),
    .pos_o     (s1_pos),
    .mag_o     (s1_mag)
  );

  // S2: (pos + L) * D for degrees, |force| * |duty span| for duty.
  // (pos + L) * 2D / 2L equals (pos + L) * D / L since pos + L >= 0.
  assign x_sum     = unsigned'(s1_pos) + POS_W'(ENCODER_LIMIT);
  assign duty_span = (duty_max_r >= duty_min_r) ? (duty_max_r - duty_min_r) :
                                                 (duty_min_r - duty_max_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_flg_r   <= s1_flg;
      s2_pos_r   <= s1_pos;
      deg_num_r  <= DEG_NUM_W'(x_sum) * DEG_NUM_W'(WHEEL_LIMIT_DEG);
      duty_num_r <= DUTY_NUM_W'(s1_mag) * DUTY_NUM_W'(duty_span);
    end
  end

  qwp_cdiv #(
    .NUM_W (DEG_NUM_W),
    .DEN   (ENCODER_LIMIT),
    .QUO_W (DEG_Q_W)
  ) u_deg_div (
    .clk   (clk),
    .en_i  (en),
    .num_i (deg_num_r),
    .quo_o (deg_q)
  );

  qwp_cdiv #(
    .NUM_W (DUTY_NUM_W),
    .DEN   (QWP_FORCE_FULL),
    .QUO_W (QWP_DUTY_W)
  ) u_duty_div (
    .clk   (clk),
    .en_i  (en),
    .num_i (duty_num_r),
    .quo_o (duty_q)
  );

  // side band keeps pace with the divider stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_vld_r <= 1'b0;
    end else if (en) begin
      sb_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_flg_r <= s2_flg_r;
      sb_pos_r <= s2_pos_r;
    end
  end

  // final stage: output register and held duty levels
  qwp_drive #(
    .ENCODER_LIMIT   (ENCODER_LIMIT),
    .WHEEL_LIMIT_DEG (WHEEL_LIMIT_DEG),
    .DEG_Q_W         (DEG_Q_W)
  ) u_drive (
    .clk             (clk),
    .rst_n           (rst_n),
    .en_i            (en),
    .vld_i           (sb_vld_r),
    .flg_i           (sb_flg_r),
    .pos_i           (sb_pos_r),
    .deg_q_i         (deg_q),
    .duty_q_i        (duty_q),
    .duty_min_i      (duty_min_r),
    .duty_max_i      (duty_max_r),
    .vld_o           (out_valid),
    .position_o      (out_position),
    .wheel_degrees_o (out_wheel_degrees),
    .out_of_range_o  (out_out_of_range),
    .motor_enable_o  (out_motor_enable),
    .right_duty_o    (out_right_duty),
    .left_duty_o     (out_left_duty)
  );

  // zero force in range always lands duty_min on the left channel
  `QWP_ASSERT_IMPL(a_zero_force_left, out_valid && !out_motor_enable && !out_out_of_range, out_left_duty == duty_min_r, "zero force did not write duty_min left")
  `QWP_ASSERT_IMPL(a_sb_pos_range, sb_vld_r, (sb_pos_r <= POS_MAX) && (sb_pos_r >= -POS_MAX), "position beyond encoder limit")

endmodule

`default_nettype wire

>>> verif/tb_quadrature_wheel_position_motor_drive_unit.sv
// ---------------------------------------------------------------------------
// tb_quadrature_wheel_position_motor_drive_unit
// Self-checking bench for the wheel encoder decode / H-bridge drive unit.
// A queue-fed driver sends encoder samples with random gaps. A monitor stalls
// the result side at random and checks every result field against an in-bench
// prediction. Duty limits are rewritten between phases.
// ---------------------------------------------------------------------------
module tb_quadrature_wheel_position_motor_drive_unit;
  import qwp_pkg::*;

  localparam int ENC_LIM     = QWP_ENCODER_LIMIT;
  localparam int DEG_LIM     = QWP_WHEEL_LIMIT_DEG;
  localparam int FULL_SCALE  = QWP_FORCE_FULL;
  // settle margin for wait_drained, above the pipe depth with the default limits
  localparam int PIPE_LAT    = 8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 160;
  localparam int MAX_PRINTS  = 50;

  // one encoder sample plus force command, as driven on the in_ channel
  typedef struct {
    bit                            ph_a;
    bit                            ph_b;
    logic signed [QWP_FORCE_W-1:0] frc;
  } sample_t;

  // one expected drive result
  typedef struct {
    logic signed [QWP_POS_W-1:0] pos;
    logic signed [QWP_DEG_W-1:0] deg;
    logic                        oor;
    logic                        en;
    logic [QWP_DUTY_W-1:0]       right;
    logic [QWP_DUTY_W-1:0]       left;
  } drive_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            in_phase_a = 1'b0;
  logic                            in_phase_b = 1'b0;
  logic signed [QWP_FORCE_W-1:0]   in_force_cmd = '0;

  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic signed [QWP_POS_W-1:0]     out_position;
  logic signed [QWP_DEG_W-1:0]     out_wheel_degrees;
  logic                            out_out_of_range;
  logic                            out_motor_enable;
  logic [QWP_DUTY_W-1:0]           out_right_duty;
  logic [QWP_DUTY_W-1:0]           out_left_duty;

  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [QWP_CFG_IDX_W-1:0]        cfg_index = QWP_CFG_DUTY_MIN;
  logic [QWP_DUTY_W-1:0]           cfg_data = '0;

  quadrature_wheel_position_motor_drive_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_phase_a        (in_phase_a),
    .in_phase_b        (in_phase_b),
    .in_force_cmd      (in_force_cmd),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_position      (out_position),
    .out_wheel_degrees (out_wheel_degrees),
    .out_out_of_range  (out_out_of_range),
    .out_motor_enable  (out_motor_enable),
    .out_right_duty    (out_right_duty),
    .out_left_duty     (out_left_duty),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // -------------------------------------------------------------------------
  // Bookkeeping
  // -------------------------------------------------------------------------
  sample_t sample_queue[$];   // requests not yet presented
  drive_t  drive_queue[$];    // predicted results, oldest first
  int      n_queued = 0;      // requests ever put into sample_queue
  int      results_seen = 0;  // results taken off the out_ channel
  int      errors = 0;
  int      cycle_count = 0;

  // predictor state, mirrors the unit's registers
  logic [31:0]           mdl_count = '0;
  logic [1:0]            mdl_phase = '0;
  logic [QWP_DUTY_W-1:0] mdl_right = '0;
  logic [QWP_DUTY_W-1:0] mdl_left = '0;
  logic [QWP_DUTY_W-1:0] mdl_duty_lo = QWP_DUTY_MIN_RST;
  logic [QWP_DUTY_W-1:0] mdl_duty_hi = QWP_DUTY_MAX_RST;

  // stimulus side phase rank, each random step moves from the last sample
  logic [1:0] gen_rank = '0;

  initial begin
    forever #10 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Prediction
  // -------------------------------------------------------------------------

  // Position of a {b,a} phase code along the forward Gray cycle
  // 00 -> 01 -> 11 -> 10. A rank difference of 1 is a forward step, 3 a
  // backward one, 2 a skipped state that counts nothing.
  function automatic logic [1:0] gray_rank(logic [1:0] ph);
    return {ph[1], ph[1] ^ ph[0]};
  endfunction

  function automatic drive_t predict_drive(sample_t s);
    logic [1:0] ph;
    logic [1:0] delta;
    longint     cnt, pos, deg, frc, mag, duty;
    bit         oor, to_right;
    drive_t     r;
    ph    = {s.ph_b, s.ph_a};
    delta = gray_rank(ph) - gray_rank(mdl_phase);
    if (delta == 2'd1) begin
      mdl_count = mdl_count + 32'd1;
    end else if (delta == 2'd3) begin
      mdl_count = mdl_count - 32'd1;
    end
    mdl_phase = ph;

    // clamp the wrapping count to the encoder limit
    cnt = longint'($signed(mdl_count));
    oor = 1'b1;
    if (cnt > ENC_LIM) begin
      pos = ENC_LIM;
    end else if (cnt < -ENC_LIM) begin
      pos = -ENC_LIM;
    end else begin
      pos = cnt;
      oor = 1'b0;
    end
    deg = (pos + ENC_LIM) * (2 * DEG_LIM) / (2 * ENC_LIM) - DEG_LIM;

    // duty map, truncating toward zero also for an inverted range
    frc = longint'(s.frc);
    mag = (frc < 0) ? -frc : frc;
    if (mag > FULL_SCALE) begin
      mag = FULL_SCALE;
    end
    duty = mag * (longint'(mdl_duty_hi) - longint'(mdl_duty_lo)) / FULL_SCALE
           + longint'(mdl_duty_lo);

    // out of range, the wheel side picks the channel, not the force sign
    to_right = oor ? (pos >= 0) : (frc > 0);
    if (to_right) begin
      mdl_right = duty[QWP_DUTY_W-1:0];
    end else begin
      mdl_left = duty[QWP_DUTY_W-1:0];
    end

    r.pos   = pos[QWP_POS_W-1:0];
    r.deg   = deg[QWP_DEG_W-1:0];
    r.oor   = oor;
    r.en    = (frc != 0);
    r.right = mdl_right;
    r.left  = mdl_left;
    return r;
  endfunction

  task automatic report(string msg);
    errors++;
    if (errors <= MAX_PRINTS) begin
      $display("[%0d] mismatch: %0s", cycle_count, msg);
    end
  endtask

  // -------------------------------------------------------------------------
  // Driver: presents queued requests, predicts each one as it is accepted.
  // A random gap is drawn per request; calm stretches run gap-free.
  // -------------------------------------------------------------------------
  int gap_left = 0;
  bit drv_calm = 1'b0;

  always @(posedge clk) begin
    sample_t s;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      // request taken at this edge: predict from the pins the unit saw
      if (in_valid && !in_stall) begin
        s.ph_a = in_phase_a;
        s.ph_b = in_phase_b;
        s.frc  = in_force_cmd;
        drive_queue.push_back(predict_drive(s));
      end
      if (in_valid && in_stall) begin
        // held: payload stays put
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (sample_queue.size() > 0) begin
        s = sample_queue.pop_front();
        in_valid     <= 1'b1;
        in_phase_a   <= s.ph_a;
        in_phase_b   <= s.ph_b;
        in_force_cmd <= s.frc;
        if ($urandom_range(0, 39) == 0) begin
          drv_calm = !drv_calm;
        end
        gap_left = drv_calm ? 0 : $urandom_range(0, 3);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: checks each accepted result against the oldest prediction and
  // draws a random stall after every result.
  // -------------------------------------------------------------------------
  int stall_left = 0;
  bit mon_calm = 1'b0;

  always @(posedge clk) begin
    drive_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (drive_queue.size() == 0) begin
          report($sformatf("result %0d with no request pending", results_seen));
        end else begin
          want = drive_queue.pop_front();
          if (out_position !== want.pos)
            report($sformatf("result %0d position: got %0d, want %0d",
                             results_seen, out_position, want.pos));
          if (out_wheel_degrees !== want.deg)
            report($sformatf("result %0d wheel_degrees: got %0d, want %0d",
                             results_seen, out_wheel_degrees, want.deg));
          if (out_out_of_range !== want.oor)
            report($sformatf("result %0d out_of_range: got %0b, want %0b",
                             results_seen, out_out_of_range, want.oor));
          if (out_motor_enable !== want.en)
            report($sformatf("result %0d motor_enable: got %0b, want %0b",
                             results_seen, out_motor_enable, want.en));
          if (out_right_duty !== want.right)
            report($sformatf("result %0d right_duty: got %0d, want %0d",
                             results_seen, out_right_duty, want.right));
          if (out_left_duty !== want.left)
            report($sformatf("result %0d left_duty: got %0d, want %0d",
                             results_seen, out_left_duty, want.left));
        end
        if ($urandom_range(0, 39) == 0) begin
          mon_calm = !mon_calm;
        end
        stall_left = mon_calm ? 0 : $urandom_range(0, 3);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  task automatic add_sample(bit a, bit b, logic signed [QWP_FORCE_W-1:0] frc);
    sample_t s;
    s.ph_a = a;
    s.ph_b = b;
    s.frc  = frc;
    gen_rank = gray_rank({b, a});
    sample_queue.push_back(s);
    n_queued++;
  endtask

  // force mix: mostly in the working range, some raw 16-bit, some corners
  function automatic logic signed [QWP_FORCE_W-1:0] rand_force();
    logic signed [QWP_FORCE_W-1:0] corner[8];
    corner = '{16'sd0, 16'sd1, -16'sd1, 16'sd10000, -16'sd10000, 16'sd10001,
               -16'sd32768, 16'sd32767};
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return QWP_FORCE_W'(int'($urandom_range(0, 2 * FULL_SCALE)) - FULL_SCALE);
      4, 5:       return QWP_FORCE_W'($urandom);
      6:          return corner[$urandom_range(0, 7)];
      default:    return QWP_FORCE_W'(int'($urandom_range(0, 6)) - 3);
    endcase
  endfunction

  // One encoder move: forward / backward with the given percentages, a few
  // skipped states, the rest a repeated sample.
  task automatic add_step(int fwd_pct, int back_pct);
    int         r;
    logic [1:0] rk;
    r = $urandom_range(0, 99);
    if (r < fwd_pct) begin
      rk = gen_rank + 2'd1;
    end else if (r < fwd_pct + back_pct) begin
      rk = gen_rank - 2'd1;
    end else if (r < fwd_pct + back_pct + 4) begin
      rk = gen_rank + 2'd2;
    end else begin
      rk = gen_rank;
    end
    add_sample(rk[1] ^ rk[0], rk[1], rand_force());
  endtask

  // idle point: every queued request answered, then the pipe left to settle
  task automatic wait_drained();
    while (results_seen < n_queued) @(posedge clk);
    repeat (PIPE_LAT) @(posedge clk);
  endtask

  task automatic write_reg(logic [QWP_CFG_IDX_W-1:0] idx, logic [QWP_DUTY_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      QWP_CFG_DUTY_MIN: mdl_duty_lo = val;
      QWP_CFG_DUTY_MAX: mdl_duty_hi = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic set_duty(logic [QWP_DUTY_W-1:0] lo, logic [QWP_DUTY_W-1:0] hi);
    write_reg(QWP_CFG_DUTY_MIN, lo);
    write_reg(QWP_CFG_DUTY_MAX, hi);
  endtask

  // -------------------------------------------------------------------------
  // Test sequence
  // -------------------------------------------------------------------------
  initial begin
    logic [QWP_DUTY_W-1:0] lo_set[6];
    logic [QWP_DUTY_W-1:0] hi_set[6];
    lo_set = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd200, 8'd0};
    hi_set = '{8'd255, 8'd0, 8'd0, 8'd255, 8'd30, 8'd0};
    lo_set[5] = QWP_DUTY_W'($urandom);
    hi_set[5] = QWP_DUTY_W'($urandom);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, at reset duty limits: a forward Gray cycle, a reverse step,
    // skipped states both ways, repeated samples, zero force, force at and
    // past full scale, the most negative command, and +/-1.
    add_sample(1, 0, 16'sd0);
    add_sample(1, 1, 16'sd1);
    add_sample(0, 1, -16'sd1);
    add_sample(0, 0, 16'sd10000);
    add_sample(0, 0, -16'sd10000);
    add_sample(1, 1, 16'sd5000);
    add_sample(0, 0, -16'sd5000);
    add_sample(0, 1, 16'sd10001);
    add_sample(1, 1, -16'sd32768);
    add_sample(1, 0, 16'sd32767);
    add_sample(0, 1, -16'sd10001);
    add_sample(0, 0, -16'sd32767);
    add_sample(0, 0, 16'sd0);
    add_sample(1, 0, -16'sd2);
    add_sample(0, 0, 16'sd2);
    add_sample(0, 1, 16'sd123);
    add_sample(0, 0, -16'sd1);
    add_sample(0, 1, 16'sd0);
    add_sample(1, 1, 16'sd9999);
    add_sample(1, 0, -16'sd9999);
    wait_drained();

    // random walks across a spread of duty settings, extremes and inverted
    foreach (lo_set[i]) begin
      set_duty(lo_set[i], hi_set[i]);
      repeat (PHASE_ITEMS) add_step(42, 42);
      wait_drained();
    end

    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/qwp_pkg.sv
hw/rtl/qwp_decode.sv
hw/rtl/qwp_cdiv.sv
hw/rtl/qwp_drive.sv
hw/rtl/quadrature_wheel_position_motor_drive_unit.sv
verif/tb_quadrature_wheel_position_motor_drive_unit.sv
